FILE: rtl/core/numeric_escape_decoder_macros.svh
// Assertion macros shared by the numeric escape decoder modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef NUMERIC_ESCAPE_DECODER_MACROS_SVH
`define NUMERIC_ESCAPE_DECODER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define NESC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define NESC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nesc_pkg.sv
// Package for the numeric escape decoder: payload and command types, codes and constants.
// Used by every module of the block; depends on nothing.
package nesc_pkg;

    localparam int CP_W           = 21;
    localparam int RES_W          = 32;
    localparam int DIG_W          = 7;
    localparam int MAX_HEX_DIGITS = 8;
    localparam int DCNT_W         = 4;
    localparam int DIDX_W         = $clog2(MAX_HEX_DIGITS);
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    localparam logic [RES_W-1:0]  LIMIT_RESET    = 32'd1114112;
    localparam logic [DCNT_W-1:0] OCT_MAX_DIGITS = 4'd3;
    localparam logic [DCNT_W-1:0] X_DIGITS       = 4'd2;
    localparam logic [DCNT_W-1:0] LU_DIGITS      = 4'd4;
    localparam logic [DCNT_W-1:0] UU_DIGITS      = DCNT_W'(MAX_HEX_DIGITS);

    localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_X         = 21'h78;
    localparam logic [CP_W-1:0] CH_LOW_U     = 21'h75;
    localparam logic [CP_W-1:0] CH_UP_U      = 21'h55;
    localparam logic [CP_W-1:0] CH_ZERO      = 21'h30;
    localparam logic [CP_W-1:0] CH_SEVEN     = 21'h37;
    localparam logic [CP_W-1:0] CH_NINE      = 21'h39;
    localparam logic [CP_W-1:0] CH_LOW_A     = 21'h61;
    localparam logic [CP_W-1:0] CH_LOW_F     = 21'h66;
    localparam logic [CP_W-1:0] CH_UP_A      = 21'h41;
    localparam logic [CP_W-1:0] CH_UP_F      = 21'h46;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_X    = 2'd1;
    localparam logic [1:0] KIND_LU   = 2'd2;
    localparam logic [1:0] KIND_UU   = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BSLASH,
        PH_HEX,
        PH_OCT
    } phase_t;

    typedef enum logic [1:0] {
        SEG_FIRST,
        SEG_PREFIX,
        SEG_DIGIT,
        SEG_TAIL
    } bk_seg_t;

    typedef struct packed {
        logic [CP_W-1:0] char_code;
        logic            is_last;
    } in_item_t;

    typedef struct packed {
        logic [RES_W-1:0] out_code_point;
        logic             out_last;
    } result_t;

    // One command describes every result caused by one input character, in order:
    // a decoded value or a backslash, a prefix letter, held digits, a trailing character.
    typedef struct packed {
        logic                                first_en;
        logic [RES_W-1:0]                    first_value;
        logic                                prefix_en;
        logic [DIG_W-1:0]                    prefix_char;
        logic [DCNT_W-1:0]                   digit_cnt;
        logic [MAX_HEX_DIGITS-1:0][DIG_W-1:0] digits;
        logic                                tail_en;
        logic [CP_W-1:0]                     tail_char;
        logic                                last;
    } cmd_t;

    function automatic logic [DCNT_W-1:0] hex_len(input logic [1:0] kind);
        logic [DCNT_W-1:0] len;
        unique case (kind)
            KIND_X:  len = X_DIGITS;
            KIND_LU: len = LU_DIGITS;
            default: len = UU_DIGITS;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/nesc_front.sv
// Front end of the numeric escape decoder: accepts characters, tracks escape state and
// builds at most one command per character for the command queue. Depends on nesc_pkg.
`include "numeric_escape_decoder_macros.svh"

module nesc_front import nesc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RES_W-1:0]    cfg_data,
    input  logic                push,
    input  in_item_t            item,
    input  logic                cmd_full,
    output logic                cmd_wr,
    output cmd_t                cmd
);

    phase_t                phase_reg, phase_next;
    logic [1:0]            kind_reg, kind_next;
    logic [DCNT_W-1:0]     count_reg, count_next;
    logic [RES_W-1:0]      acc_reg, acc_next;
    logic [RES_W-1:0]      limit_reg;
    logic [DIG_W-1:0]      held_reg [MAX_HEX_DIGITS];

    logic [CP_W-1:0]       c;
    logic                  last;
    logic                  accept;
    logic                  is_bs, is_prefix, is_oct, is_dec, hex_ok;
    logic [3:0]            hex_d;
    logic [RES_W-1:0]      acc_hex, acc_oct, val_sel;
    logic [DCNT_W-1:0]     cnt_inc, cnt_sel;
    logic                  hex_done, oct_done, dig_take, fin_ok;
    logic                  do_finish, do_flush, after_plain, pre_en, cmd_valid;
    logic [DIG_W-1:0]      pre_char;
    logic [1:0]            kind_of_c;
    logic [MAX_HEX_DIGITS-1:0][DIG_W-1:0] held_vec;

    function automatic logic [DIG_W-1:0] kind_char(input logic [1:0] kind);
        logic [DIG_W-1:0] ch;
        unique case (kind)
            KIND_X:  ch = CH_X[DIG_W-1:0];
            KIND_LU: ch = CH_LOW_U[DIG_W-1:0];
            default: ch = CH_UP_U[DIG_W-1:0];
        endcase
        return ch;
    endfunction

    assign c         = item.char_code;
    assign last      = item.is_last;
    assign accept    = push && !cmd_full;
    assign cfg_ready = 1'b1;

    assign is_bs     = (c == CH_BACKSLASH);
    assign is_prefix = (c == CH_X) || (c == CH_LOW_U) || (c == CH_UP_U);
    assign is_oct    = (c >= CH_ZERO) && (c <= CH_SEVEN);
    assign is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign hex_ok    = is_dec || ((c >= CH_LOW_A) && (c <= CH_LOW_F))
                       || ((c >= CH_UP_A) && (c <= CH_UP_F));
    assign hex_d     = is_dec ? c[3:0] : c[3:0] + 4'd9;
    assign kind_of_c = (c == CH_X) ? KIND_X : (c == CH_LOW_U) ? KIND_LU : KIND_UU;

    assign acc_hex  = {acc_reg[RES_W-5:0], hex_d};
    assign acc_oct  = {acc_reg[RES_W-4:0], c[2:0]};
    assign cnt_inc  = count_reg + 4'd1;
    assign hex_done = (cnt_inc >= hex_len(kind_reg));
    assign oct_done = (cnt_inc >= OCT_MAX_DIGITS);

    assign dig_take = ((phase_reg == PH_HEX) && hex_ok)
                      || (((phase_reg == PH_OCT) || (phase_reg == PH_BSLASH)) && is_oct);
    assign val_sel  = !dig_take ? acc_reg : ((phase_reg == PH_HEX) ? acc_hex : acc_oct);
    assign cnt_sel  = dig_take ? cnt_inc : count_reg;
    assign fin_ok   = (val_sel != '0) && (val_sel < limit_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_HEX_DIGITS; i++)
        begin
            held_vec[i] = held_reg[i];
        end
        if (dig_take)
        begin
            held_vec[count_reg[DIDX_W-1:0]] = c[DIG_W-1:0];
        end
    end

    assign do_finish = ((phase_reg == PH_HEX) && hex_ok && hex_done)
                       || ((phase_reg == PH_OCT) && is_oct && (oct_done || last))
                       || ((phase_reg == PH_OCT) && !is_oct)
                       || ((phase_reg == PH_BSLASH) && is_oct && last);
    assign do_flush  = ((phase_reg == PH_HEX) && hex_ok && !hex_done && last)
                       || ((phase_reg == PH_HEX) && !hex_ok)
                       || ((phase_reg == PH_BSLASH) && is_prefix && last);
    assign after_plain = (phase_reg == PH_IDLE)
                         || ((phase_reg == PH_HEX) && !hex_ok)
                         || ((phase_reg == PH_OCT) && !is_oct);
    assign pre_en   = (phase_reg == PH_HEX) || ((phase_reg == PH_BSLASH) && is_prefix);
    assign pre_char = (phase_reg == PH_BSLASH) ? c[DIG_W-1:0] : kind_char(kind_reg);

    // Next state of the escape tracker.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_next = (is_bs && !last) ? PH_BSLASH : PH_IDLE;
            end
            PH_BSLASH:
            begin
                if (is_prefix && !last)
                begin
                    phase_next = PH_HEX;
                end
                else if (is_oct && !last)
                begin
                    phase_next = PH_OCT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HEX:
            begin
                if (hex_ok)
                begin
                    phase_next = (hex_done || last) ? PH_IDLE : PH_HEX;
                end
                else
                begin
                    phase_next = (is_bs && !last) ? PH_BSLASH : PH_IDLE;
                end
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    phase_next = (oct_done || last) ? PH_IDLE : PH_OCT;
                end
                else
                begin
                    phase_next = (is_bs && !last) ? PH_BSLASH : PH_IDLE;
                end
            end
        endcase

        kind_next  = ((phase_reg == PH_BSLASH) && is_prefix) ? kind_of_c : kind_reg;
        count_next = ((phase_next == PH_HEX) || (phase_next == PH_OCT)) ? cnt_sel : '0;
        acc_next   = ((phase_next == PH_HEX) || (phase_next == PH_OCT)) ? val_sel : '0;
    end

    // Command built from the current character.
    always_comb
    begin
        cmd = '0;
        if (do_finish && fin_ok)
        begin
            cmd.first_en    = 1'b1;
            cmd.first_value = val_sel;
        end
        else if (do_finish || do_flush)
        begin
            cmd.first_en    = 1'b1;
            cmd.first_value = RES_W'(CH_BACKSLASH);
            cmd.prefix_en   = pre_en;
            cmd.prefix_char = pre_char;
            cmd.digit_cnt   = cnt_sel;
            cmd.digits      = held_vec;
        end
        if ((phase_reg == PH_BSLASH) && !is_prefix && !is_oct)
        begin
            cmd.first_en    = 1'b1;
            cmd.first_value = RES_W'(CH_BACKSLASH);
            cmd.tail_en     = 1'b1;
            cmd.tail_char   = c;
        end
        if (after_plain && !(is_bs && !last))
        begin
            cmd.tail_en   = 1'b1;
            cmd.tail_char = c;
        end
        cmd.last  = last;
        cmd_valid = cmd.first_en || cmd.tail_en;
    end

    assign cmd_wr = accept && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_NONE;
            count_reg <= '0;
            acc_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dig_take)
        begin
            held_reg[count_reg[DIDX_W-1:0]] <= c[DIG_W-1:0];
        end
    end

    `NESC_ASSERT_IMPL(a_hex_count_short, phase_reg == PH_HEX, count_reg < hex_len(kind_reg), "hex escape holds a full set of digits")
    `NESC_ASSERT_IMPL(a_bslash_clean, phase_reg == PH_BSLASH, (count_reg == '0) && (acc_reg == '0), "escape state not cleared after backslash")

endmodule

FILE: rtl/core/nesc_cmd_fifo.sv
// Short command queue between the front and back ends of the numeric escape decoder.
// Depends on nesc_pkg for the command type and depth.
`include "numeric_escape_decoder_macros.svh"

module nesc_cmd_fifo import nesc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    output logic full,
    input  logic rd,
    output cmd_t rdata,
    output logic empty
);

    cmd_t                 mem_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_wr, do_rd;

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        return (p == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `NESC_ASSERT_ALWAYS(a_count_bound, count_reg <= CMD_CNT_W'(CMD_FIFO_DEPTH), "command queue count beyond depth")
    `NESC_ASSERT_NEXT(a_count_grows, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1, "command queue count did not grow")

endmodule

FILE: rtl/core/nesc_back.sv
// Back end of the numeric escape decoder: expands each queued command into result beats
// and holds them in the output register. Depends on nesc_pkg.
`include "numeric_escape_decoder_macros.svh"

module nesc_back import nesc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  logic    fifo_empty,
    output logic    fifo_rd,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    bk_seg_t           seg_reg, seg_next, cur_seg;
    logic [DIDX_W-1:0] idx_reg, idx_next;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              advance, idx_last, item_final;
    logic [RES_W-1:0]  item_value;

    assign idx_last = ((DCNT_W'(idx_reg) + 4'd1) == head.digit_cnt);
    assign advance  = !fifo_empty && (!out_valid_reg || pop);

    always_comb
    begin
        priority if ((seg_reg == SEG_FIRST) && head.first_en)
        begin
            cur_seg = SEG_FIRST;
        end
        else if (((seg_reg == SEG_FIRST) || (seg_reg == SEG_PREFIX)) && head.prefix_en)
        begin
            cur_seg = SEG_PREFIX;
        end
        else if ((seg_reg == SEG_DIGIT) || ((seg_reg != SEG_TAIL) && (head.digit_cnt != '0)))
        begin
            cur_seg = SEG_DIGIT;
        end
        else
        begin
            cur_seg = SEG_TAIL;
        end
    end

    // Output of the sequencer: the current beat and whether it ends the command.
    always_comb
    begin
        unique case (cur_seg)
            SEG_FIRST:
            begin
                item_value = head.first_value;
                item_final = !head.prefix_en && (head.digit_cnt == '0) && !head.tail_en;
            end
            SEG_PREFIX:
            begin
                item_value = RES_W'(head.prefix_char);
                item_final = (head.digit_cnt == '0) && !head.tail_en;
            end
            SEG_DIGIT:
            begin
                item_value = RES_W'(head.digits[idx_reg]);
                item_final = idx_last && !head.tail_en;
            end
            SEG_TAIL:
            begin
                item_value = RES_W'(head.tail_char);
                item_final = 1'b1;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        seg_next = seg_reg;
        idx_next = idx_reg;
        if (advance)
        begin
            if (item_final)
            begin
                seg_next = SEG_FIRST;
                idx_next = '0;
            end
            else
            begin
                unique case (cur_seg)
                    SEG_FIRST:
                    begin
                        seg_next = SEG_PREFIX;
                    end
                    SEG_PREFIX:
                    begin
                        seg_next = (head.digit_cnt != '0) ? SEG_DIGIT : SEG_TAIL;
                    end
                    SEG_DIGIT:
                    begin
                        seg_next = idx_last ? SEG_TAIL : SEG_DIGIT;
                        idx_next = idx_reg + 1'b1;
                    end
                    SEG_TAIL:
                    begin
                        seg_next = SEG_FIRST;
                    end
                endcase
            end
        end
    end

    assign fifo_rd = advance && item_final;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_FIRST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            idx_reg <= idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_code_point <= item_value;
            out_reg.out_last       <= head.last && item_final;
        end
    end

    `NESC_ASSERT_IMPL(a_head_kept, seg_reg != SEG_FIRST, !fifo_empty, "command left the queue before its last beat")
    `NESC_ASSERT_IMPL(a_digit_in_range, seg_reg == SEG_DIGIT, DCNT_W'(idx_reg) < head.digit_cnt, "digit index past held digits")

endmodule

FILE: rtl/core/numeric_escape_decoder.sv
// Top level of the numeric escape decoder.
// Depends on nesc_pkg, nesc_front, nesc_cmd_fifo and nesc_back.
//
// The decoder takes one character per cycle while the queue is not full and gives at most
// one result beat per cycle. A character is classified in the cycle it is accepted and its
// command enters a four-entry queue; the back end turns each command into one to ten
// result beats, one per cycle while results are popped, and its output register shows the
// oldest beat once the command has passed through the queue. Most characters give one beat,
// so the sustained rate is one character per cycle while results are popped; an escape
// flushed raw gives up to ten beats, during which input is still taken until the queue is
// full. The code point limit resets to 0x110000 and may be written whenever the block is
// idle; cfg_ready is always high. No clearing pass follows reset.
module numeric_escape_decoder import nesc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RES_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    output logic             empty,
    input  logic             pop,
    output result_t          result
);

    cmd_t wr_cmd, head_cmd;
    logic cmd_wr, cmd_full, cmd_rd, cmd_empty;

    assign full = cmd_full;

    nesc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .cmd_full  (cmd_full),
        .cmd_wr    (cmd_wr),
        .cmd       (wr_cmd)
    );

    nesc_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .wdata (wr_cmd),
        .full  (cmd_full),
        .rd    (cmd_rd),
        .rdata (head_cmd),
        .empty (cmd_empty)
    );

    nesc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .fifo_empty (cmd_empty),
        .fifo_rd    (cmd_rd),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
